@@ sv/ufd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared widths, constants and the packet types passed between the parts of
// the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package ufd_pkg;

  localparam int CP_W  = 21;
  localparam int ACC_W = 31;
  localparam int REM_W = 3;

  // Queue between front and back end
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CP_W-1:0]  REPL_CP  = 21'h00FFFD;
  localparam logic [ACC_W-1:0] BOM_VAL  = 31'h0000FEFF;
  localparam logic [ACC_W-1:0] SURR_LO  = 31'h0000D800;
  localparam logic [ACC_W-1:0] SURR_HI  = 31'h0000DFFF;
  localparam logic [ACC_W-1:0] NONCH_A  = 31'h0000FFFE;
  localparam logic [ACC_W-1:0] NONCH_B  = 31'h0000FFFF;
  localparam logic [ACC_W-1:0] MAX_CP   = 31'h0010FFFF;

  // One decoded result
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
  } result_t;

  // All results caused by one byte: one, or two when a sequence is broken
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } packet_t;

endpackage

@@ sv/ufd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder channel interfaces
// Byte input, result output and configuration write channels, each with
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface ufd_in_if import ufd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface ufd_out_if import ufd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            replaced;
  logic            last_of_run;

  modport source(output valid, output code_point, output replaced, output last_of_run,
                 input ready);
  modport sink(input valid, input code_point, input replaced, input last_of_run,
               output ready);
endinterface

interface ufd_cfg_if import ufd_pkg::*; ();
  logic valid;
  logic ready;
  logic drop_bom;

  modport source(output valid, output drop_bom, input ready);
  modport sink(input valid, input drop_bom, output ready);
endinterface

@@ sv/utf8_code_point_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 code point decoder
// Decodes a UTF-8 byte stream into Unicode scalar values, replacing every stray,
// broken, truncated or out-of-range sequence and U+FFFE/U+FFFF with U+FFFD.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload                                 | Beat
//  ---------+-----------+-----------------------------------------+------------------
//  in_ch    | sink      | data_byte[7:0], last_byte               | one input byte
//  out_ch   | source    | code_point[20:0], replaced, last_of_run | one result
//  cfg_ch   | sink      | drop_bom                                | register write
//
// One byte is taken per cycle while the packet queue has room; the front end
// settles each byte in the cycle it is accepted. The output carries one result
// per cycle while the receiver is ready, so a byte that breaks a sequence and
// gives two results takes two output beats; the four-entry packet queue absorbs
// this. Synchronous reset clears sequence state, queue pointers and valid and
// pending flags and sets drop_bom to 1. Either side may stall without loss.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder_core import ufd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ufd_in_if.sink    in_ch,
  ufd_out_if.source out_ch,
  ufd_cfg_if.sink   cfg_ch
);

  logic    fq_valid, fq_ready;
  packet_t fq_pkt;
  logic    qb_valid, qb_ready;
  packet_t qb_pkt;

  // Byte classification and sequence state
  ufd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .pkt_valid (fq_valid),
    .pkt_ready (fq_ready),
    .pkt       (fq_pkt)
  );

  // Decoupling queue
  ufd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_pkt   (fq_pkt),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_pkt    (qb_pkt)
  );

  // Result output
  ufd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_valid (qb_valid),
    .pkt_ready (qb_ready),
    .pkt       (qb_pkt),
    .out_ch    (out_ch)
  );

endmodule

@@ sv/ufd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks the pending sequence and classifies each byte into a
// packet of zero, one or two results for the queue.
// ----------------------------------------------------------------------------
module ufd_front import ufd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  ufd_in_if.sink        in_ch,
  ufd_cfg_if.sink       cfg_ch,
  output logic          pkt_valid,
  input  logic          pkt_ready,
  output packet_t       pkt
);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic             drop_bom_r;

  logic             accept;
  logic [7:0]       b;
  logic             is_cont;
  logic [ACC_W-1:0] cont_acc;
  logic             intr;
  logic             do_lead;
  logic             flt;
  logic             fin_req;
  logic [ACC_W-1:0] fin_val;
  logic             bad_val;
  logic             is_bom;
  logic             res_vld;
  result_t          res;

  assign b       = in_ch.data_byte;
  assign is_cont = (b[7:6] == 2'b10);
  assign cont_acc = {acc_r[ACC_W-7:0], b[5:0]};

  // Next state and result classification for the byte on the input
  always_comb begin
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    intr    = 1'b0;
    do_lead = 1'b0;
    flt     = 1'b0;
    fin_req = 1'b0;
    fin_val = '0;
    if (rem_r != '0) begin
      if (is_cont) begin
        rem_nxt = rem_r - 3'd1;
        if (rem_r == 3'd1) begin
          fin_req = 1'b1;
          fin_val = cont_acc;
          acc_nxt = '0;
        end else if (in_ch.last_byte) begin
          acc_nxt = '0;
          rem_nxt = '0;
          flt     = 1'b1;
        end else begin
          acc_nxt = cont_acc;
        end
      end else begin
        // Broken sequence: replace it, then take this byte as a new lead
        intr    = 1'b1;
        acc_nxt = '0;
        rem_nxt = '0;
        do_lead = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end

    if (do_lead) begin
      if (b[7] == 1'b0) begin
        fin_req = 1'b1;
        fin_val = {{(ACC_W-8){1'b0}}, b};
      end else if (b[7:6] == 2'b10 || b[7:1] == 7'b1111111) begin
        flt = 1'b1;
      end else if (in_ch.last_byte) begin
        acc_nxt = '0;
        rem_nxt = '0;
        flt     = 1'b1;
      end else if (b[5] == 1'b0) begin
        acc_nxt = {{(ACC_W-5){1'b0}}, b[4:0]};
        rem_nxt = 3'd1;
      end else if (b[4] == 1'b0) begin
        acc_nxt = {{(ACC_W-4){1'b0}}, b[3:0]};
        rem_nxt = 3'd2;
      end else if (b[3] == 1'b0) begin
        acc_nxt = {{(ACC_W-3){1'b0}}, b[2:0]};
        rem_nxt = 3'd3;
      end else if (b[2] == 1'b0) begin
        acc_nxt = {{(ACC_W-2){1'b0}}, b[1:0]};
        rem_nxt = 3'd4;
      end else begin
        acc_nxt = {{(ACC_W-1){1'b0}}, b[0]};
        rem_nxt = 3'd5;
      end
    end
  end

  // Range check on a finished value
  assign bad_val = (fin_val >= SURR_LO && fin_val <= SURR_HI) || fin_val == NONCH_A ||
                   fin_val == NONCH_B || fin_val > MAX_CP;
  assign is_bom  = (fin_val == BOM_VAL);

  assign res_vld = flt || (fin_req && (bad_val || !(is_bom && drop_bom_r)));
  assign res.code_point = (flt || bad_val) ? REPL_CP : fin_val[CP_W-1:0];
  assign res.replaced   = flt || bad_val;

  // Packet towards the queue
  assign pkt.two               = intr && res_vld;
  assign pkt.first.code_point  = intr ? REPL_CP : res.code_point;
  assign pkt.first.replaced    = intr ? 1'b1 : res.replaced;
  assign pkt.second            = res;

  assign in_ch.ready = pkt_ready;
  assign accept      = in_ch.valid && pkt_ready;
  assign pkt_valid   = accept && (intr || res_vld);

  assign cfg_ch.ready = 1'b1;

  // Sequence state and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      rem_r      <= '0;
      drop_bom_r <= 1'b1;
    end else begin
      if (accept) begin
        acc_r <= acc_nxt;
        rem_r <= rem_nxt;
      end
      if (cfg_ch.valid) begin
        drop_bom_r <= cfg_ch.drop_bom;
      end
    end
  end

`ifndef SYNTHESIS
  // No lead byte asks for more than five continuation bytes
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n) rem_r <= 3'd5)
    else $error("continuation count out of range");

  // With nothing pending the accumulator is clear
  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r == '0 |-> acc_r == '0)
    else $error("accumulator holds data with no sequence pending");
`endif

endmodule

@@ sv/ufd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder packet queue
// Small first-in first-out store that decouples the front end from the
// result output.
// ----------------------------------------------------------------------------
module ufd_queue import ufd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  packet_t push_pkt,
  output logic    pop_valid,
  input  logic    pop_ready,
  output packet_t pop_pkt
);

  packet_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 push;
  logic                 pop;

  assign push_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_pkt    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Packet storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue fill count beyond depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue fill count missed a push");
`endif

endmodule

@@ sv/ufd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Unpacks queued packets into single results on a registered output, one
// result per beat, marking the last result of each byte.
// ----------------------------------------------------------------------------
module ufd_back import ufd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     pkt_valid,
  output logic     pkt_ready,
  input  packet_t  pkt,
  ufd_out_if.source out_ch
);

  logic            out_vld_r;
  result_t         out_res_r;
  logic            out_last_r;
  logic            sec_pend_r;
  result_t         sec_r;
  logic            load;

  assign load      = !out_vld_r || out_ch.ready;
  assign pkt_ready = load && !sec_pend_r;

  // Output register and held second result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      sec_pend_r <= 1'b0;
    end else if (load) begin
      if (sec_pend_r) begin
        out_vld_r  <= 1'b1;
        sec_pend_r <= 1'b0;
      end else begin
        out_vld_r  <= pkt_valid;
        sec_pend_r <= pkt_valid && pkt.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_pend_r) begin
        out_res_r  <= sec_r;
        out_last_r <= 1'b1;
      end else if (pkt_valid) begin
        out_res_r  <= pkt.first;
        out_last_r <= !pkt.two;
        sec_r      <= pkt.second;
      end
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.code_point  = out_res_r.code_point;
  assign out_ch.replaced    = out_res_r.replaced;
  assign out_ch.last_of_run = out_last_r;

`ifndef SYNTHESIS
  // A held second result always sits behind a shown first one
  a_sec_behind: assert property (@(posedge clk) disable iff (!rst_n)
    sec_pend_r |-> out_vld_r && !out_last_r)
    else $error("second result pending without its first on the output");
`endif

endmodule

@@ test/utf8_code_point_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 code point decoder testbench
// Drives byte strings into the decoder and checks every decoded result
// against a cycle-free behavioural predictor. The tests cover directed corner
// cases, the byte order mark register, back-pressure and random traffic.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder_core_tb;
  import ufd_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_CYC   = 8;
  localparam int TARGET_BYTES = 1050;
  localparam int HOLD_CYC     = 80;
  localparam int MAX_REPORTS  = 10;

  // One expected result beat
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            last_of_run;
  } cp_beat_t;

  logic clk;
  logic rst_n;

  ufd_in_if  in_ch ();
  ufd_out_if out_ch ();
  ufd_cfg_if cfg_ch ();

  utf8_code_point_decoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: partial value, continuation bytes still due, register copy
  logic [ACC_W-1:0] partial_q;
  logic [REM_W-1:0] conts_due_q;
  logic             drop_bom_q;

  // Results of the byte being predicted, then the queue of expected beats
  cp_beat_t byte_beats [2];
  int       byte_beat_n;
  cp_beat_t pending_code_points [$];

  int  mismatch_count;
  int  bytes_sent;
  int  idle_cycles;
  int  rx_hold;
  bit  tx_idle;
  bit  rx_idle;

  // Clock with a 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void add_beat(input logic [CP_W-1:0] cp, input logic rep);
    byte_beats[byte_beat_n] = '{code_point: cp, replaced: rep, last_of_run: 1'b0};
    byte_beat_n++;
  endfunction

  // A finished value: out-of-range and non-characters become U+FFFD.
  function automatic void settle_value(input logic [ACC_W-1:0] v);
    if ((v >= SURR_LO && v <= SURR_HI) || v == NONCH_A || v == NONCH_B || v > MAX_CP)
      add_beat(REPL_CP, 1'b1);
    else if (!(v == BOM_VAL && drop_bom_q))
      add_beat(v[CP_W-1:0], 1'b0);
  endfunction

  // A byte seen with no sequence pending.
  function automatic void start_sequence(input logic [7:0] b, input logic lst);
    logic [REM_W-1:0] need;
    logic [ACC_W-1:0] val;
    need = '0;
    val  = '0;
    if (b < 8'h80) begin
      settle_value({{(ACC_W-8){1'b0}}, b});
    end else if (b < 8'hC0 || b >= 8'hFE) begin
      add_beat(REPL_CP, 1'b1);
    end else begin
      if (b < 8'hE0) begin
        need = 3'd1;
        val  = ACC_W'(b[4:0]);
      end else if (b < 8'hF0) begin
        need = 3'd2;
        val  = ACC_W'(b[3:0]);
      end else if (b < 8'hF8) begin
        need = 3'd3;
        val  = ACC_W'(b[2:0]);
      end else if (b < 8'hFC) begin
        need = 3'd4;
        val  = ACC_W'(b[1:0]);
      end else begin
        need = 3'd5;
        val  = ACC_W'(b[0]);
      end
      if (lst) begin
        partial_q   = '0;
        conts_due_q = '0;
        add_beat(REPL_CP, 1'b1);
      end else begin
        partial_q   = val;
        conts_due_q = need;
      end
    end
  endfunction

  // Works out the beats that one accepted byte causes and queues them.
  function automatic void predict_code_points(input logic [7:0] b, input logic lst);
    logic [ACC_W-1:0] v;
    byte_beat_n = 0;
    if (conts_due_q != '0) begin
      if (b[7:6] == 2'b10) begin
        partial_q   = {partial_q[ACC_W-7:0], b[5:0]};
        conts_due_q = conts_due_q - 3'd1;
        if (conts_due_q == '0) begin
          v         = partial_q;
          partial_q = '0;
          settle_value(v);
        end else if (lst) begin
          partial_q   = '0;
          conts_due_q = '0;
          add_beat(REPL_CP, 1'b1);
        end
      end else begin
        // The sequence is broken: replace it, then take the byte as a new lead.
        partial_q   = '0;
        conts_due_q = '0;
        add_beat(REPL_CP, 1'b1);
        start_sequence(b, lst);
      end
    end else begin
      start_sequence(b, lst);
    end
    if (byte_beat_n > 0)
      byte_beats[byte_beat_n-1].last_of_run = 1'b1;
    for (int i = 0; i < byte_beat_n; i++)
      pending_code_points = {pending_code_points, byte_beats[i]};
  endfunction

  // ------------------------------------------------------------ encoding help

  function automatic int min_len(input logic [ACC_W-1:0] v);
    if (v < 31'h80) return 1;
    if (v < 31'h800) return 2;
    if (v < 31'h10000) return 3;
    if (v < 31'h200000) return 4;
    if (v < 31'h4000000) return 5;
    return 6;
  endfunction

  // Byte idx of the len-byte encoding of v.
  function automatic logic [7:0] utf8_byte(input logic [ACC_W-1:0] v, input int len,
                                           input int idx);
    logic [ACC_W-1:0] part;
    logic [7:0]       lead;
    part = v >> (6 * (len - 1 - idx));
    if (idx > 0) return {2'b10, part[5:0]};
    if (len == 1) return {1'b0, part[6:0]};
    lead = 8'hFF << (8 - len);
    return lead | (part[7:0] & (8'hFF >> (len + 1)));
  endfunction

  // ------------------------------------------------------------------ drivers

  // Offers one byte, waits for its beat, then predicts its results.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    predict_code_points(b, lst);
  endtask

  // Sends the first cnt bytes of the len-byte encoding of v.
  task automatic send_char(input logic [ACC_W-1:0] v, input int len, input int cnt,
                           input logic lst);
    for (int i = 0; i < cnt; i++)
      send_byte(utf8_byte(v, len, i), lst && (i == cnt - 1));
  endtask

  // Stops offering and waits until every expected beat has come out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_code_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_drop_bom(input logic v);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.drop_bom <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    drop_bom_q = v;
  endtask

  // Receiver: random stalls per beat, plus a long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      int stall;
      stall = 0;
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else if (rx_idle) begin
        stall = $urandom_range(0, 8);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare every output beat with the oldest expectation.
  always @(posedge clk) begin
    cp_beat_t got;
    cp_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{code_point: out_ch.code_point, replaced: out_ch.replaced,
              last_of_run: out_ch.last_of_run};
      if (pending_code_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected beat cp=%h rep=%b last=%b", $realtime,
                   got.code_point, got.replaced, got.last_of_run);
      end else begin
        want = pending_code_points.pop_front();
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch expected cp=%h rep=%b last=%b, got cp=%h rep=%b last=%b",
                     $realtime, want.code_point, want.replaced, want.last_of_run,
                     got.code_point, got.replaced, got.last_of_run);
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $realtime, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------- tests

  // Field extremes and irregular input forms.
  task automatic test_directed_bytes();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // Stray continuation and the two invalid leads
    send_byte(8'h80, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Two-byte form and an overlong NUL
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b1);
    // Byte order mark, dropped after reset
    send_char(31'hFEFF, 3, 3, 1'b1);
    // Surrogate and the highest scalar value
    send_char(31'hD800, 3, 3, 1'b0);
    send_char(31'h10FFFF, 4, 4, 1'b1);
    // Sequence broken by an ASCII byte, then one cut short by the string end
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    // Lead byte that is itself the last byte
    send_byte(8'hC3, 1'b1);
    wait_idle();
  endtask

  // The byte order mark passes when dropping is off.
  task automatic test_bom_register();
    write_drop_bom(1'b0);
    send_char(31'hFEFF, 3, 3, 1'b1);
    wait_idle();
    write_drop_bom(1'b1);
  endtask

  // Long receiver hold-off while the sender keeps offering.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = HOLD_CYC;
    for (int i = 0; i < 40; i++)
      send_byte(8'($urandom_range(0, 8'h7F)), (i % 7) == 6);
    // The sender now pauses until every beat has drained.
    wait_idle();
  endtask

  // One random string of well-formed, special and broken characters.
  task automatic send_random_string();
    int               n_chars;
    int               kind;
    int               len;
    logic [ACC_W-1:0] v;
    logic             lst;
    n_chars = $urandom_range(1, 8);
    for (int k = 0; k < n_chars; k++) begin
      kind = $urandom_range(0, 99);
      lst  = (k == n_chars - 1);
      if (kind < 70) begin
        case ($urandom_range(0, 3))
          0: v = ACC_W'($urandom_range(0, 'h7F));
          1: v = ACC_W'($urandom_range('h80, 'h7FF));
          2: v = ACC_W'($urandom_range('h800, 'hFFFF));
          default: v = ACC_W'($urandom_range('h10000, 'h10FFFF));
        endcase
        len = min_len(v);
        // Now and then an overlong form
        if ($urandom_range(0, 9) == 0) len = $urandom_range(len, 6);
        send_char(v, len, len, lst);
      end else if (kind < 80) begin
        case ($urandom_range(0, 6))
          0: v = ACC_W'($urandom_range('hD800, 'hDFFF));
          1: v = 31'hFFFE;
          2: v = 31'hFFFF;
          3: v = 31'hFEFF;
          4: v = 31'hFFFD;
          5: v = 31'h10FFFF;
          default: v = ACC_W'($urandom_range('h110000, 'h7FFFFFFF));
        endcase
        len = min_len(v);
        send_char(v, len, len, lst);
      end else if (kind < 92) begin
        // Cut-short sequence: broken by the next character or by the string end
        v   = ACC_W'($urandom);
        len = $urandom_range(2, 6);
        send_char(v, len, $urandom_range(1, len - 1), lst);
      end else begin
        send_byte(8'($urandom_range(0, 255)), lst);
      end
    end
  endtask

  // Phases of random strings, each with its own register value and idling mode.
  task automatic test_random_traffic();
    int phase;
    int phase_end;
    phase = 0;
    while (bytes_sent < TARGET_BYTES) begin
      wait_idle();
      write_drop_bom(phase < 2 ? phase[0] : 1'($urandom_range(0, 1)));
      tx_idle   = (phase % 4 == 0) || (phase % 4 == 1);
      rx_idle   = (phase % 4 == 0) || (phase % 4 == 2);
      phase_end = bytes_sent + 150;
      while (bytes_sent < phase_end && bytes_sent < TARGET_BYTES)
        send_random_string();
      phase++;
    end
    wait_idle();
  endtask

  // ------------------------------------------------------------------- main

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.drop_bom = 1'b0;
    partial_q       = '0;
    conts_due_q     = '0;
    drop_bom_q      = 1'b1;
    mismatch_count  = 0;
    bytes_sent      = 0;
    idle_cycles     = 0;
    rx_hold         = 0;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_bytes();
    test_bom_register();
    test_backpressure();
    test_random_traffic();

    if (mismatch_count == 0 && pending_code_points.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ utf8_code_point_decoder_core.f @@
sv/ufd_pkg.sv
sv/ufd_if.sv
sv/ufd_front.sv
sv/ufd_queue.sv
sv/ufd_back.sv
sv/utf8_code_point_decoder_core.sv
test/utf8_code_point_decoder_core_tb.sv
